### design/biou_pkg.sv
`default_nettype none
package biou_pkg;

    localparam int CoordBits = 16;
    localparam int FracBits  = 16;
    localparam int RatioBits = FracBits + 1;
    localparam int MeasBits  = 2 * CoordBits;
    localparam int UniBits   = MeasBits + 1;
    localparam int WorkBits  = UniBits + 1;
    localparam int NumCells  = RatioBits;

    typedef logic [1:0] t_mode;
    localparam t_mode ModeArea  = 2'd0;
    localparam t_mode ModeHoriz = 2'd1;
    localparam t_mode ModeVert  = 2'd2;
    localparam t_mode ModeSpare = 2'd3;

    typedef struct packed {
        t_mode                mode;
        logic [CoordBits-1:0] a_x;
        logic [CoordBits-1:0] a_y;
        logic [CoordBits-1:0] a_width;
        logic [CoordBits-1:0] a_height;
        logic [CoordBits-1:0] b_x;
        logic [CoordBits-1:0] b_y;
        logic [CoordBits-1:0] b_width;
        logic [CoordBits-1:0] b_height;
    } t_item;

    typedef struct packed {
        logic [RatioBits-1:0] ratio;
        logic                 empty_union;
    } t_result;

    // one slot of the divider chain
    typedef struct packed {
        logic [WorkBits-1:0]  work;
        logic [UniBits-1:0]   den;
        logic [RatioBits-1:0] quot;
        logic                 force_zero;
        logic                 empty;
    } t_cell;

endpackage
`default_nettype wire

### design/biou_front.sv
`default_nettype none
module biou_front
    import biou_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_cell o_cell
);

    // stage 1: edges of the overlap rectangle
    logic                 r_v1;
    t_mode                r_mode1;
    logic [CoordBits-1:0] r_x0, r_y0;
    logic [CoordBits:0]   r_x1, r_y1;
    logic [CoordBits-1:0] r_aw1, r_ah1, r_bw1, r_bh1;
    logic [CoordBits:0]   n_ar, n_ab, n_br, n_bb;

    // stage 2: overlap extents and kill flag
    logic                 r_v2;
    t_mode                r_mode2;
    logic                 r_kill2;
    logic [CoordBits-1:0] r_ow, r_oh;
    logic [CoordBits-1:0] r_aw2, r_ah2, r_bw2, r_bh2;
    logic [CoordBits:0]   n_ow, n_oh;

    // stage 3: measures
    logic                 r_v3;
    logic                 r_kill3;
    logic [MeasBits-1:0]  r_ma, r_mb, r_ov;
    logic [MeasBits-1:0]  n_ma, n_mb, n_ov;

    // stage 4: union
    logic [UniBits-1:0]   n_uni;
    logic                 n_uzero;

    assign n_ar = {1'b0, i_item.a_x} + {1'b0, i_item.a_width};
    assign n_br = {1'b0, i_item.b_x} + {1'b0, i_item.b_width};
    assign n_ab = {1'b0, i_item.a_y} + {1'b0, i_item.a_height};
    assign n_bb = {1'b0, i_item.b_y} + {1'b0, i_item.b_height};

    assign n_ow = r_x1 - {1'b0, r_x0};
    assign n_oh = r_y1 - {1'b0, r_y0};

    always_comb begin
        n_ma = '0;
        n_mb = '0;
        n_ov = '0;
        unique case (r_mode2)
            ModeArea: begin
                n_ma = MeasBits'(r_aw2) * MeasBits'(r_ah2);
                n_mb = MeasBits'(r_bw2) * MeasBits'(r_bh2);
                n_ov = MeasBits'(r_ow) * MeasBits'(r_oh);
            end
            ModeHoriz: begin
                n_ma = {{CoordBits{1'b0}}, r_aw2};
                n_mb = {{CoordBits{1'b0}}, r_bw2};
                n_ov = {{CoordBits{1'b0}}, r_ow};
            end
            ModeVert: begin
                n_ma = {{CoordBits{1'b0}}, r_ah2};
                n_mb = {{CoordBits{1'b0}}, r_bh2};
                n_ov = {{CoordBits{1'b0}}, r_oh};
            end
            default: begin
                n_ma = '0;
                n_mb = '0;
                n_ov = '0;
            end
        endcase
    end

    assign n_uni   = {1'b0, r_ma} + {1'b0, r_mb} - {1'b0, r_ov};
    assign n_uzero = (n_uni == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            o_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode1 <= i_item.mode;
        r_x0    <= (i_item.a_x > i_item.b_x) ? i_item.a_x : i_item.b_x;
        r_y0    <= (i_item.a_y > i_item.b_y) ? i_item.a_y : i_item.b_y;
        r_x1    <= (n_ar < n_br) ? n_ar : n_br;
        r_y1    <= (n_ab < n_bb) ? n_ab : n_bb;
        r_aw1   <= i_item.a_width;
        r_ah1   <= i_item.a_height;
        r_bw1   <= i_item.b_width;
        r_bh1   <= i_item.b_height;

        r_mode2 <= r_mode1;
        // unused mode and disjoint boxes both end as a plain zero
        r_kill2 <= (r_mode1 == ModeSpare) || (r_x1 < {1'b0, r_x0}) || (r_y1 < {1'b0, r_y0});
        r_ow    <= n_ow[CoordBits-1:0];
        r_oh    <= n_oh[CoordBits-1:0];
        r_aw2   <= r_aw1;
        r_ah2   <= r_ah1;
        r_bw2   <= r_bw1;
        r_bh2   <= r_bh1;

        r_kill3 <= r_kill2;
        r_ma    <= n_ma;
        r_mb    <= n_mb;
        r_ov    <= n_ov;

        o_cell.work       <= {2'b00, r_ov};
        o_cell.den        <= n_uni;
        o_cell.quot       <= '0;
        o_cell.force_zero <= r_kill3 || n_uzero;
        o_cell.empty      <= !r_kill3 && n_uzero;
    end

endmodule
`default_nettype wire

### design/biou_div_cell.sv
`default_nettype none
module biou_div_cell
    import biou_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    input  t_cell i_cell,
    output logic  o_valid,
    output t_cell o_cell
);

    logic                n_ge;
    logic [WorkBits-1:0] n_diff;
    logic [UniBits-1:0]  n_rem;

    assign n_ge   = (i_cell.work >= {1'b0, i_cell.den});
    assign n_diff = i_cell.work - {1'b0, i_cell.den};
    // remainder stays below the divisor, so it fits the divisor width
    assign n_rem  = n_ge ? n_diff[UniBits-1:0] : i_cell.work[UniBits-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_cell.work       <= {n_rem, 1'b0};
        o_cell.den        <= i_cell.den;
        o_cell.quot       <= {i_cell.quot[RatioBits-2:0], n_ge};
        o_cell.force_zero <= i_cell.force_zero;
        o_cell.empty      <= i_cell.empty;
    end

endmodule
`default_nettype wire

### design/box_iou_calculator.sv
// channel  | handshake        | payload   | transfer when
// ---------+------------------+-----------+------------------------
// input    | start / busy     | i_item    | start high, busy low
// result   | o_strobe         | o_result  | o_strobe high, one cycle
//
// one pair per cycle; busy is always low
// result passes through 4 geometry/measure stages after the input transfer,
// then one cell per quotient bit (17) in the restoring divider chain
// synchronous active-low reset clears the valid bits only
// the receiver cannot stall, so the chain never holds
`default_nettype none
module box_iou_calculator
    import biou_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_strobe,
    output t_result o_result
);

    logic  w_valid [NumCells+1];
    t_cell w_cell  [NumCells+1];

    assign busy = 1'b0;

    biou_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_item  (i_item),
        .o_valid (w_valid[0]),
        .o_cell  (w_cell[0])
    );

    for (genvar g = 0; g < NumCells; g++) begin : g_cell
        biou_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_cell  (w_cell[g]),
            .o_valid (w_valid[g+1]),
            .o_cell  (w_cell[g+1])
        );
    end

    assign o_strobe             = w_valid[NumCells];
    assign o_result.ratio       = w_cell[NumCells].force_zero ? '0 : w_cell[NumCells].quot;
    assign o_result.empty_union = w_cell[NumCells].empty;

endmodule
`default_nettype wire

### tb/tb_box_iou_calculator.sv
`timescale 1ns / 1ps
module tb_box_iou_calculator
    import biou_pkg::*;
();

    localparam int    StallLimit = 1000;
    localparam int    DrainWait  = 40;
    localparam int    MaxReports = 10;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_item   i_item  = '0;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    t_result iou_pending[$];
    t_result iou_want;
    int      mismatch_cnt = 0;
    int      quiet_cycles = 0;
    bit      idle_on      = 1'b1;

    box_iou_calculator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // overlap over union of the two boxes, Q1.16 truncated
    function automatic t_result iou_expected(input t_item it);
        logic [16:0] left, top, right, bottom, a_end, b_end;
        logic [63:0] meas_a, meas_b, overlap, uni;
        t_result     res;
        res    = '0;
        left   = (it.a_x > it.b_x) ? {1'b0, it.a_x} : {1'b0, it.b_x};
        top    = (it.a_y > it.b_y) ? {1'b0, it.a_y} : {1'b0, it.b_y};
        a_end  = {1'b0, it.a_x} + {1'b0, it.a_width};
        b_end  = {1'b0, it.b_x} + {1'b0, it.b_width};
        right  = (a_end < b_end) ? a_end : b_end;
        a_end  = {1'b0, it.a_y} + {1'b0, it.a_height};
        b_end  = {1'b0, it.b_y} + {1'b0, it.b_height};
        bottom = (a_end < b_end) ? a_end : b_end;
        if (it.mode != ModeSpare && right >= left && bottom >= top) begin
            case (it.mode)
                ModeArea: begin
                    meas_a  = 64'(it.a_width) * 64'(it.a_height);
                    meas_b  = 64'(it.b_width) * 64'(it.b_height);
                    overlap = 64'(right - left) * 64'(bottom - top);
                end
                ModeHoriz: begin
                    meas_a  = 64'(it.a_width);
                    meas_b  = 64'(it.b_width);
                    overlap = 64'(right - left);
                end
                default: begin
                    meas_a  = 64'(it.a_height);
                    meas_b  = 64'(it.b_height);
                    overlap = 64'(bottom - top);
                end
            endcase
            uni = meas_a + meas_b - overlap;
            if (uni == 64'd0) begin
                res.empty_union = 1'b1;
            end else begin
                res.ratio = RatioBits'((overlap << FracBits) / uni);
            end
        end
        return res;
    endfunction

    function automatic t_item box_pair(input t_mode m,
                                       input logic [15:0] ax, ay, aw, ah,
                                       input logic [15:0] bx, by, bw, bh);
        t_item it;
        it.mode     = m;
        it.a_x      = ax;
        it.a_y      = ay;
        it.a_width  = aw;
        it.a_height = ah;
        it.b_x      = bx;
        it.b_y      = by;
        it.b_width  = bw;
        it.b_height = bh;
        return it;
    endfunction

    function automatic t_mode pick_mode();
        if ($urandom_range(0, 15) == 0) begin
            return ModeSpare;
        end
        return t_mode'($urandom_range(0, 2));
    endfunction

    // mostly overlapping pairs with random scale, plus raw, identical, flat and abutting
    function automatic t_item random_pair();
        t_item       it;
        int unsigned kind;
        int unsigned sh;
        logic [15:0] mask;
        kind        = $urandom_range(0, 11);
        sh          = $urandom_range(0, 16);
        mask        = 16'((32'd1 << sh) - 1);
        it.mode     = pick_mode();
        it.a_x      = 16'($urandom);
        it.a_y      = 16'($urandom);
        it.a_width  = 16'($urandom) & mask;
        it.a_height = 16'($urandom) & mask;
        it.b_x      = it.a_x + (16'($urandom) & mask) - (16'($urandom) & mask);
        it.b_y      = it.a_y + (16'($urandom) & mask) - (16'($urandom) & mask);
        it.b_width  = 16'($urandom) & mask;
        it.b_height = 16'($urandom) & mask;
        case (kind)
            0, 1: begin
                it = box_pair(pick_mode(), 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom));
            end
            2: begin
                it.b_x      = it.a_x;
                it.b_y      = it.a_y;
                it.b_width  = it.a_width;
                it.b_height = it.a_height;
            end
            3: begin
                if ($urandom_range(0, 1) == 0) begin
                    it.a_width = '0;
                    it.b_width = '0;
                    it.b_x     = ($urandom_range(0, 3) == 0) ? it.a_x + 16'd1 : it.a_x;
                end else begin
                    it.a_height = '0;
                    it.b_height = '0;
                    it.b_y      = ($urandom_range(0, 3) == 0) ? it.a_y + 16'd1 : it.a_y;
                end
            end
            4: begin
                if ($urandom_range(0, 1) == 0) begin
                    it.b_x = it.a_x + it.a_width;
                end else begin
                    it.b_y = it.a_y + it.a_height;
                end
            end
            default: begin
            end
        endcase
        return it;
    endfunction

    task automatic send_box_pair(input t_item it);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            start  <= 1'b0;
            i_item <= random_pair();
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic test_field_extremes();
        send_box_pair(box_pair(ModeArea, '0, '0, '0, '0, '0, '0, '0, '0));
        send_box_pair(box_pair(ModeArea, '1, '1, '1, '1, '1, '1, '1, '1));
        send_box_pair(box_pair(ModeHoriz, '0, '0, '1, '1, '1, '1, '1, '1));
        send_box_pair(box_pair(ModeArea, '0, '0, '1, '1, '1, '1, '1, '1));
        send_box_pair(box_pair(ModeVert, '1, '0, '0, '1, '0, '1, '1, '0));
        send_box_pair(box_pair(ModeArea, '0, '0, '1, '1, 16'd1, 16'd1, 16'hfffe, 16'hfffe));
    endtask

    task automatic test_each_mode();
        send_box_pair(box_pair(ModeArea, 16'd10, 16'd20, 16'd100, 16'd50,
                               16'd60, 16'd40, 16'd100, 16'd50));
        send_box_pair(box_pair(ModeHoriz, 16'd10, 16'd20, 16'd100, 16'd50,
                               16'd60, 16'd40, 16'd100, 16'd50));
        send_box_pair(box_pair(ModeVert, 16'd10, 16'd20, 16'd100, 16'd50,
                               16'd60, 16'd40, 16'd100, 16'd50));
        send_box_pair(box_pair(ModeSpare, 16'd10, 16'd20, 16'd100, 16'd50,
                               16'd60, 16'd40, 16'd100, 16'd50));
    endtask

    task automatic test_special_cases();
        // disjoint on one axis gives zero whatever the mode
        send_box_pair(box_pair(ModeHoriz, 16'd0, 16'd0, 16'd10, 16'd10,
                               16'd20, 16'd0, 16'd10, 16'd10));
        send_box_pair(box_pair(ModeHoriz, 16'd0, 16'd0, 16'd10, 16'd10,
                               16'd5, 16'd30, 16'd10, 16'd10));
        send_box_pair(box_pair(ModeArea, 16'd0, 16'd0, 16'd10, 16'd10,
                               16'd5, 16'd30, 16'd10, 16'd10));
        send_box_pair(box_pair(ModeVert, 16'd0, 16'd0, 16'd10, 16'd10,
                               16'd30, 16'd5, 16'd10, 16'd10));
        // abutting edges, zero overlap
        send_box_pair(box_pair(ModeArea, 16'd0, 16'd0, 16'd10, 16'd10,
                               16'd10, 16'd0, 16'd10, 16'd10));
        // zero union
        send_box_pair(box_pair(ModeHoriz, 16'd7, 16'd0, 16'd0, 16'd5,
                               16'd7, 16'd2, 16'd0, 16'd5));
        send_box_pair(box_pair(ModeVert, 16'd0, 16'd9, 16'd5, 16'd0,
                               16'd3, 16'd9, 16'd5, 16'd0));
        send_box_pair(box_pair(ModeArea, 16'd3, 16'd3, 16'd0, 16'd8,
                               16'd3, 16'd3, 16'd0, 16'd4));
        // flat boxes that miss each other, then identical boxes and one box inside another
        send_box_pair(box_pair(ModeHoriz, 16'd7, 16'd0, 16'd0, 16'd5,
                               16'd8, 16'd0, 16'd0, 16'd5));
        send_box_pair(box_pair(ModeVert, 16'd40, 16'd50, 16'd7, 16'd9,
                               16'd40, 16'd50, 16'd7, 16'd9));
        send_box_pair(box_pair(ModeArea, 16'd0, 16'd0, 16'd200, 16'd100,
                               16'd50, 16'd20, 16'd30, 16'd40));
        // one third, truncated
        send_box_pair(box_pair(ModeHoriz, 16'd0, 16'd0, 16'd3, 16'd1,
                               16'd0, 16'd0, 16'd1, 16'd1));
    endtask

    task automatic test_random_traffic(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 49) == 0) begin
                idle_on = ~idle_on;
            end
            send_box_pair(random_pair());
        end
        idle_on = 1'b1;
    endtask

    // sender holds off until every result is back
    task automatic test_drain_pause(input int count);
        for (int n = 0; n < count; n++) begin
            send_box_pair(random_pair());
        end
        start <= 1'b0;
        while (iou_pending.size() != 0) @(posedge i_clk);
        for (int n = 0; n < count; n++) begin
            send_box_pair(random_pair());
        end
    endtask

    task automatic test_back_to_back(input int count);
        idle_on = 1'b0;
        for (int n = 0; n < count; n++) begin
            send_box_pair(random_pair());
        end
    endtask

    task automatic note_mismatch(input bit have_want, input t_result want, input t_result got);
        mismatch_cnt++;
        if (mismatch_cnt <= MaxReports) begin
            if (have_want) begin
                $display("ratio/empty expected %h/%b actual %h/%b", want.ratio,
                         want.empty_union, got.ratio, got.empty_union);
            end else begin
                $display("unexpected result ratio %h empty %b", got.ratio, got.empty_union);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            iou_pending.push_back(iou_expected(i_item));
        end
        if (i_rst_n && o_strobe) begin
            if (iou_pending.size() == 0) begin
                note_mismatch(1'b0, '0, o_result);
            end else begin
                iou_want = iou_pending.pop_front();
                if (o_result.ratio !== iou_want.ratio ||
                    o_result.empty_union !== iou_want.empty_union) begin
                    note_mismatch(1'b1, iou_want, o_result);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= StallLimit) begin
            $display("box_iou_calculator: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_field_extremes();
        test_each_mode();
        test_special_cases();
        test_random_traffic(700);
        test_drain_pause(20);
        test_random_traffic(100);
        test_back_to_back(200);
        start <= 1'b0;
        while (iou_pending.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        if (mismatch_cnt == 0 && iou_pending.size() == 0) begin
            $display("box_iou_calculator: match");
        end else begin
            $display("box_iou_calculator: mismatch");
        end
        $finish;
    end

endmodule
